// ===== sv/csl_pkg.sv =====
// Shared constants, codes and interface structs of the sparse matrix lookup block.
package csl_pkg;

    // Store capacity.
    localparam int MAX_ROWS    = 256;
    localparam int MAX_ENTRIES = 1024;

    // Derived widths: addresses, and counts that can hold the capacity itself.
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int ENT_AW = $clog2(MAX_ENTRIES);
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int EC_W   = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths of the beats.
    localparam int KEY_W = 32;
    localparam int VAL_W = 64;
    localparam int OFF_W = 11;

    // Command codes of an input beat.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_GLOBAL = 2'd2,
        OP_LOCAL  = 2'd3
    } op_t;

    // Kinds of result that the datapath can post.
    typedef enum logic [2:0] {
        RES_CLEAR   = 3'd0,
        RES_STORED  = 3'd1,
        RES_FULL    = 3'd2,
        RES_INVALID = 3'd3,
        RES_FOUND   = 3'd4,
        RES_MISSING = 3'd5
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic append;
        logic row_begin;
        logic row_step;
        logic sel_local;
        logic sel_hit;
        logic ofs_hi_rd;
        logic ofs_cap;
        logic col_step;
        logic finish;
        res_t res_code;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic key_zero;
        logic local_oob;
        logic full;
        logic rows_empty;
        logic row_hit;
        logic row_done;
        logic col_hit;
        logic col_done;
    } dp_status_t;

endpackage

// ===== sv/csl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module csl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/csl_dpath.sv =====
// Datapath of the sparse matrix lookup: counts, tables, scan pointers and result register.
module csl_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    command,
    input  logic [csl_pkg::KEY_W-1:0]     row_key,
    input  logic [csl_pkg::KEY_W-1:0]     col_key,
    input  logic [csl_pkg::VAL_W-1:0]     entry_value,
    input  csl_pkg::dp_cmd_t              cmd,
    output csl_pkg::dp_status_t           status,
    output logic                          done,
    output logic [csl_pkg::VAL_W-1:0]     value_out,
    output logic [csl_pkg::OFF_W-1:0]     offset_out,
    output logic                          error_flag
);

    // Captured input beat.
    csl_pkg::op_t                   op_reg;
    logic [csl_pkg::KEY_W-1:0]      rk_reg;
    logic [csl_pkg::KEY_W-1:0]      ck_reg;
    logic [csl_pkg::VAL_W-1:0]      ev_reg;

    // Store counts and the id of the last opened row.
    logic [csl_pkg::RC_W-1:0]       rc_reg;
    logic [csl_pkg::EC_W-1:0]       ec_reg;
    logic [csl_pkg::KEY_W-1:0]      last_id_reg;

    // Row scan pipeline.
    logic [csl_pkg::RC_W-1:0]       riss_reg;
    logic                           rvalid_reg;
    logic [csl_pkg::ROW_AW-1:0]     rpend_reg;
    logic [csl_pkg::ROW_AW-1:0]     sel_reg;

    // Column scan pipeline.
    logic [csl_pkg::EC_W-1:0]       start_reg;
    logic [csl_pkg::EC_W-1:0]       end_reg;
    logic [csl_pkg::EC_W-1:0]       cptr_reg;
    logic                           cvalid_reg;
    logic [csl_pkg::EC_W-1:0]       cpend_reg;

    // Result register.
    logic                           done_reg;
    logic [csl_pkg::VAL_W-1:0]      value_reg;
    logic [csl_pkg::OFF_W-1:0]      offset_reg;
    logic                           error_reg;
    logic [csl_pkg::VAL_W-1:0]      value_next;
    logic [csl_pkg::OFF_W-1:0]      offset_next;
    logic                           error_next;

    // Table ports.
    logic [csl_pkg::KEY_W-1:0]      rid_rdata;
    logic [csl_pkg::EC_W-1:0]       rend_rdata;
    logic [csl_pkg::KEY_W-1:0]      col_rdata;
    logic [csl_pkg::VAL_W-1:0]      val_rdata;
    logic [csl_pkg::ROW_AW-1:0]     rend_waddr;
    logic [csl_pkg::ROW_AW-1:0]     rend_raddr;
    logic [csl_pkg::ROW_AW-1:0]     rc_idx;
    logic [csl_pkg::EC_W-1:0]       ec_inc;
    logic                           open_row;
    logic                           rid_we;

    assign rc_idx   = rc_reg[csl_pkg::ROW_AW-1:0];
    assign ec_inc   = ec_reg + csl_pkg::EC_W'(1);
    assign open_row = (rc_reg == '0) || (last_id_reg != rk_reg);
    assign rid_we   = cmd.append && open_row;

    // A new row ends at the slot just written; otherwise the current row grows.
    assign rend_waddr = open_row ? rc_idx : (rc_idx - csl_pkg::ROW_AW'(1));
    assign rend_raddr = cmd.ofs_hi_rd ? sel_reg : (sel_reg - csl_pkg::ROW_AW'(1));

    // Status toward the controller.
    always_comb
    begin
        status.op         = op_reg;
        status.key_zero   = (rk_reg == '0) || (ck_reg == '0);
        status.local_oob  = rk_reg > csl_pkg::KEY_W'(rc_reg);
        status.full       = (ec_reg >= csl_pkg::EC_W'(csl_pkg::MAX_ENTRIES))
                            || (open_row && (rc_reg >= csl_pkg::RC_W'(csl_pkg::MAX_ROWS)));
        status.rows_empty = (rc_reg == '0);
        status.row_hit    = rvalid_reg && (rid_rdata == rk_reg);
        status.row_done   = !rvalid_reg && (riss_reg == rc_reg);
        status.col_hit    = cvalid_reg && (col_rdata == ck_reg);
        status.col_done   = !cvalid_reg && (cptr_reg >= end_reg);
    end

    // Row id table.
    csl_ram #(
        .WIDTH (csl_pkg::KEY_W),
        .DEPTH (csl_pkg::MAX_ROWS)
    ) u_row_ids (
        .clk   (clk),
        .we    (rid_we),
        .waddr (rc_idx),
        .wdata (rk_reg),
        .raddr (riss_reg[csl_pkg::ROW_AW-1:0]),
        .rdata (rid_rdata)
    );

    // Row end offsets: slot r holds the entry count at the end of row r.
    csl_ram #(
        .WIDTH (csl_pkg::EC_W),
        .DEPTH (csl_pkg::MAX_ROWS)
    ) u_row_ends (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (rend_waddr),
        .wdata (ec_inc),
        .raddr (rend_raddr),
        .rdata (rend_rdata)
    );

    // Column id table.
    csl_ram #(
        .WIDTH (csl_pkg::KEY_W),
        .DEPTH (csl_pkg::MAX_ENTRIES)
    ) u_columns (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (ec_reg[csl_pkg::ENT_AW-1:0]),
        .wdata (ck_reg),
        .raddr (cptr_reg[csl_pkg::ENT_AW-1:0]),
        .rdata (col_rdata)
    );

    // Value table.
    csl_ram #(
        .WIDTH (csl_pkg::VAL_W),
        .DEPTH (csl_pkg::MAX_ENTRIES)
    ) u_values (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (ec_reg[csl_pkg::ENT_AW-1:0]),
        .wdata (ev_reg),
        .raddr (cptr_reg[csl_pkg::ENT_AW-1:0]),
        .rdata (val_rdata)
    );

    // Capture of the accepted beat.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= csl_pkg::op_t'(command);
            rk_reg <= row_key;
            ck_reg <= col_key;
            ev_reg <= entry_value;
        end
    end

    // Store counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= '0;
            ec_reg <= '0;
        end
        else if (cmd.clear)
        begin
            rc_reg <= '0;
            ec_reg <= '0;
        end
        else if (cmd.append)
        begin
            if (open_row)
            begin
                rc_reg <= rc_reg + csl_pkg::RC_W'(1);
            end
            ec_reg <= ec_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rid_we)
        begin
            last_id_reg <= rk_reg;
        end
    end

    // Row scan: one row id read issued per cycle, compared in the cycle after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            riss_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else if (cmd.row_begin)
        begin
            riss_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else if (cmd.row_step)
        begin
            if (riss_reg < rc_reg)
            begin
                riss_reg   <= riss_reg + csl_pkg::RC_W'(1);
                rvalid_reg <= 1'b1;
            end
            else
            begin
                rvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_step)
        begin
            rpend_reg <= riss_reg[csl_pkg::ROW_AW-1:0];
        end
    end

    // Selected row, from a local index or from the row scan hit.
    always_ff @(posedge clk)
    begin
        if (cmd.sel_local)
        begin
            sel_reg <= rk_reg[csl_pkg::ROW_AW-1:0] - csl_pkg::ROW_AW'(1);
        end
        else if (cmd.sel_hit)
        begin
            sel_reg <= rpend_reg;
        end
    end

    // Row bounds: the first row starts at zero.
    always_ff @(posedge clk)
    begin
        if (cmd.ofs_hi_rd)
        begin
            start_reg <= (sel_reg == '0) ? '0 : rend_rdata;
        end
        if (cmd.ofs_cap)
        begin
            end_reg <= rend_rdata;
        end
    end

    // Column scan: one entry read issued per cycle, compared in the cycle after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cptr_reg   <= '0;
            cvalid_reg <= 1'b0;
        end
        else if (cmd.ofs_cap)
        begin
            cptr_reg   <= start_reg;
            cvalid_reg <= 1'b0;
        end
        else if (cmd.col_step)
        begin
            if (cptr_reg < end_reg)
            begin
                cptr_reg   <= cptr_reg + csl_pkg::EC_W'(1);
                cvalid_reg <= 1'b1;
            end
            else
            begin
                cvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.col_step)
        begin
            cpend_reg <= cptr_reg;
        end
    end

    // Result fields for each kind of outcome.
    always_comb
    begin
        value_next  = '0;
        offset_next = '0;
        error_next  = 1'b0;
        case (cmd.res_code)
            csl_pkg::RES_CLEAR:
            begin
                offset_next = '0;
            end
            csl_pkg::RES_STORED:
            begin
                offset_next = csl_pkg::OFF_W'(ec_reg);
            end
            csl_pkg::RES_FULL:
            begin
                offset_next = csl_pkg::OFF_W'(ec_reg);
                error_next  = 1'b1;
            end
            csl_pkg::RES_INVALID:
            begin
                error_next = 1'b1;
            end
            csl_pkg::RES_FOUND:
            begin
                value_next  = val_rdata;
                offset_next = csl_pkg::OFF_W'(cpend_reg);
            end
            csl_pkg::RES_MISSING:
            begin
                offset_next = csl_pkg::OFF_W'(ec_reg);
            end
            default:
            begin
                error_next = 1'b1;
            end
        endcase
    end

    // Result register: the strobe lasts one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_reg  <= value_next;
            offset_reg <= offset_next;
            error_reg  <= error_next;
        end
    end

    assign done       = done_reg;
    assign value_out  = value_reg;
    assign offset_out = offset_reg;
    assign error_flag = error_reg;

endmodule

// ===== sv/csl_ctrl.sv =====
// Controller state machine of the sparse matrix lookup.
module csl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  csl_pkg::dp_status_t  status,
    output csl_pkg::dp_cmd_t     cmd,
    output logic                 busy
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_ROW_SCAN = 7'b0000100,
        S_OFS_LO   = 7'b0001000,
        S_OFS_HI   = 7'b0010000,
        S_OFS_CAP  = 7'b0100000,
        S_COL_SCAN = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (status.op)
                    csl_pkg::OP_CLEAR:
                    begin
                        cmd.clear    = 1'b1;
                        cmd.finish   = 1'b1;
                        cmd.res_code = csl_pkg::RES_CLEAR;
                    end
                    csl_pkg::OP_APPEND:
                    begin
                        cmd.finish = 1'b1;
                        if (status.full)
                        begin
                            cmd.res_code = csl_pkg::RES_FULL;
                        end
                        else
                        begin
                            cmd.append   = 1'b1;
                            cmd.res_code = csl_pkg::RES_STORED;
                        end
                    end
                    csl_pkg::OP_LOCAL:
                    begin
                        if (status.key_zero || status.local_oob)
                        begin
                            cmd.finish   = 1'b1;
                            cmd.res_code = csl_pkg::RES_INVALID;
                        end
                        else
                        begin
                            cmd.sel_local = 1'b1;
                            state_next    = S_OFS_LO;
                        end
                    end
                    csl_pkg::OP_GLOBAL:
                    begin
                        if (status.key_zero || status.rows_empty)
                        begin
                            cmd.finish   = 1'b1;
                            cmd.res_code = csl_pkg::RES_INVALID;
                        end
                        else
                        begin
                            cmd.row_begin = 1'b1;
                            state_next    = S_ROW_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.finish   = 1'b1;
                        cmd.res_code = csl_pkg::RES_INVALID;
                    end
                endcase
            end
            S_ROW_SCAN:
            begin
                cmd.row_step = 1'b1;
                if (status.row_hit)
                begin
                    cmd.sel_hit = 1'b1;
                    state_next  = S_OFS_LO;
                end
                else if (status.row_done)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_code = csl_pkg::RES_INVALID;
                    state_next   = S_IDLE;
                end
            end
            S_OFS_LO:
            begin
                state_next = S_OFS_HI;
            end
            S_OFS_HI:
            begin
                cmd.ofs_hi_rd = 1'b1;
                state_next    = S_OFS_CAP;
            end
            S_OFS_CAP:
            begin
                cmd.ofs_cap = 1'b1;
                state_next  = S_COL_SCAN;
            end
            S_COL_SCAN:
            begin
                cmd.col_step = 1'b1;
                if (status.col_hit)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_code = csl_pkg::RES_FOUND;
                    state_next   = S_IDLE;
                end
                else if (status.col_done)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_code = csl_pkg::RES_MISSING;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== sv/csr_sparse_matrix_lookup.sv =====
// Top level of the compressed-sparse-row element store with lookup.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// command selects clear, append of (row_key, col_key, entry_value), lookup by
// global row id, or lookup by 1-based local row index. Every beat yields exactly
// one result beat on value_out, offset_out and error_flag, marked by a one-cycle
// done strobe; the receiver must take it, as there is no back pressure.
// Clear, append and a lookup rejected for a zero key, an empty store or a local
// index out of range are settled in the decode state. A lookup by local index
// then reads the row bounds in the offset states (low, high, capture) and scans
// the row's entries in order until the column matches or the row ends. A lookup
// by global id first scans the row ids in order until one matches; an unknown
// id gives its error once all rows are scanned. The worst case is a global
// lookup that misses in the last row, since the rows before it and its own
// entries share the 1024 entry slots.
// busy stays high until the result is posted, and the next command may be
// taken in the cycle in which done is high.
// Reset empties the store (row and entry counts go to zero); no table clearing
// pass is needed, since the counts bound every table read.
module csr_sparse_matrix_lookup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [csl_pkg::KEY_W-1:0]     row_key,
    input  logic [csl_pkg::KEY_W-1:0]     col_key,
    input  logic [csl_pkg::VAL_W-1:0]     entry_value,
    output logic                          done,
    output logic [csl_pkg::VAL_W-1:0]     value_out,
    output logic [csl_pkg::OFF_W-1:0]     offset_out,
    output logic                          error_flag
);

    csl_pkg::dp_cmd_t    cmd;
    csl_pkg::dp_status_t status;

    // Sequencing of each command.
    csl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Tables, counts and result register.
    csl_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .row_key     (row_key),
        .col_key     (col_key),
        .entry_value (entry_value),
        .cmd         (cmd),
        .status      (status),
        .done        (done),
        .value_out   (value_out),
        .offset_out  (offset_out),
        .error_flag  (error_flag)
    );

endmodule

// ===== sv/csl_checker.sv =====
// Port-level checker of the sparse matrix lookup, bound to the top level.
module csl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    command,
    input logic [csl_pkg::KEY_W-1:0]     row_key,
    input logic [csl_pkg::KEY_W-1:0]     col_key,
    input logic [csl_pkg::VAL_W-1:0]     entry_value,
    input logic                          done,
    input logic [csl_pkg::VAL_W-1:0]     value_out,
    input logic [csl_pkg::OFF_W-1:0]     offset_out,
    input logic                          error_flag
);

    // An accepted command beat always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a command beat");

    // A result beat closes the command: busy drops exactly as done rises.
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat outside the end of a command");

    // An error result never carries value bits.
    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_flag) |-> (value_out == '0))
        else $error("error result with nonzero value");

    // Offsets never pass the store capacity.
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (offset_out <= csl_pkg::OFF_W'(csl_pkg::MAX_ENTRIES)))
        else $error("result offset beyond the store capacity");

endmodule

bind csr_sparse_matrix_lookup csl_checker u_csl_checker (.*);

// ===== verif/tb_csr_sparse_matrix_lookup.sv =====
// Testbench for csr_sparse_matrix_lookup: command beats checked against a shadow store.
`timescale 1ns / 1ps

module tb_csr_sparse_matrix_lookup;
    import csl_pkg::*;

    localparam int IDLE_LIMIT   = 8000;
    localparam int RANDOM_ITEMS = 170;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [OFF_W-1:0] offset;
        logic             err;
    } lookup_res_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] rk;
        logic [KEY_W-1:0] ck;
        logic [VAL_W-1:0] ev;
        logic             fixed;
        lookup_res_t      want;
    } stim_row_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic [1:0]       command     = OP_CLEAR;
    logic [KEY_W-1:0] row_key     = '0;
    logic [KEY_W-1:0] col_key     = '0;
    logic [VAL_W-1:0] entry_value = '0;
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] value_out;
    logic [OFF_W-1:0] offset_out;
    logic             error_flag;

    // Shadow copy of the store.
    int               sh_rows;
    int               sh_entries;
    logic [KEY_W-1:0] sh_row_id    [MAX_ROWS];
    int               sh_row_start [MAX_ROWS + 1];
    logic [KEY_W-1:0] sh_col       [MAX_ENTRIES];
    logic [VAL_W-1:0] sh_val       [MAX_ENTRIES];

    lookup_res_t pending_results [$];
    int          failures    = 0;
    int          issued_items = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;

    // Directed beats; a set fixed bit means the result is typed in.
    stim_row_t dir_tab [22] = '{
        '{OP_GLOBAL, 32'd5, 32'd1, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_LOCAL, 32'd1, 32'd1, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_APPEND, 32'd0, 32'd0, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b0}},
        '{OP_APPEND, 32'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{OP_APPEND, 32'd5, 32'd3, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{OP_APPEND, 32'hFFFF_FFFF, 32'd1, 64'h8000_0000_0000_0000, 1'b0, '0},
        '{OP_APPEND, 32'hFFFF_FFFF, 32'd7, 64'h7FF0_0000_0000_0001, 1'b0, '0},
        '{OP_APPEND, 32'd5, 32'd4, 64'h3FF0_0000_0000_0000, 1'b0, '0},
        '{OP_GLOBAL, 32'd5, 32'd4, 64'd0, 1'b0, '0},
        '{OP_GLOBAL, 32'd5, 32'd3, 64'd0, 1'b0, '0},
        '{OP_GLOBAL, 32'hFFFF_FFFF, 32'd7, 64'd0, 1'b0, '0},
        '{OP_LOCAL, 32'd4, 32'd4, 64'd0, 1'b0, '0},
        '{OP_LOCAL, 32'd1, 32'hFFFF_FFFF, 64'd0, 1'b0, '0},
        '{OP_LOCAL, 32'd5, 32'd1, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_LOCAL, 32'hFFFF_FFFF, 32'd1, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_GLOBAL, 32'd5, 32'd0, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_GLOBAL, 32'd0, 32'd3, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_GLOBAL, 32'd12345, 32'd1, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0},
        '{OP_LOCAL, 32'd1, 32'd1, 64'd0, 1'b1, '{64'd0, 11'd0, 1'b1}},
        '{OP_APPEND, 32'd9, 32'd9, 64'hDEAD_BEEF_0000_0001, 1'b1, '{64'd0, 11'd0, 1'b0}},
        '{OP_GLOBAL, 32'd9, 32'd9, 64'd0, 1'b0, '0}
    };

    csr_sparse_matrix_lookup i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .row_key     (row_key),
        .col_key     (col_key),
        .entry_value (entry_value),
        .done        (done),
        .value_out   (value_out),
        .offset_out  (offset_out),
        .error_flag  (error_flag)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one accepted beat to the shadow store and returns its result.
    function automatic lookup_res_t store_step(input op_t op, input logic [KEY_W-1:0] rk,
                                               input logic [KEY_W-1:0] ck,
                                               input logic [VAL_W-1:0] ev);
        lookup_res_t res;
        logic        open_row;
        int          r;
        int          s;
        int          row_sel;
        bit          hit;
        res = '0;
        case (op)
            OP_CLEAR:
            begin
                sh_rows         = 0;
                sh_entries      = 0;
                sh_row_start[0] = 0;
            end
            OP_APPEND:
            begin
                open_row = (sh_rows == 0) || (sh_row_id[sh_rows - 1] != rk);
                res.offset = OFF_W'(sh_entries);
                if (sh_entries >= MAX_ENTRIES || (open_row && sh_rows >= MAX_ROWS))
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    if (open_row)
                    begin
                        sh_row_id[sh_rows] = rk;
                        sh_rows++;
                    end
                    sh_col[sh_entries] = ck;
                    sh_val[sh_entries] = ev;
                    sh_entries++;
                    sh_row_start[sh_rows] = sh_entries;
                end
            end
            default:
            begin
                // Find the row, then scan its columns in order.
                row_sel = -1;
                if (rk != 0 && ck != 0)
                begin
                    if (op == OP_LOCAL)
                    begin
                        if (rk <= sh_rows)
                            row_sel = int'(rk) - 1;
                    end
                    else
                    begin
                        for (r = 0; r < sh_rows && row_sel < 0; r++)
                            if (sh_row_id[r] == rk)
                                row_sel = r;
                    end
                end
                if (row_sel < 0)
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    res.offset = OFF_W'(sh_entries);
                    hit = 1'b0;
                    for (s = sh_row_start[row_sel]; s < sh_row_start[row_sel + 1] && !hit; s++)
                    begin
                        if (sh_col[s] == ck)
                        begin
                            res.value  = sh_val[s];
                            res.offset = OFF_W'(s);
                            hit        = 1'b1;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_row_id();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(1, 20);
            2: return (sh_rows > 0) ? sh_row_id[$urandom_range(0, sh_rows - 1)] : 32'd7;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_col();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 15);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Drives one command beat, waits for its acceptance and records its result.
    task automatic issue(input op_t op, input logic [KEY_W-1:0] rk,
                         input logic [KEY_W-1:0] ck, input logic [VAL_W-1:0] ev,
                         input bit fixed = 1'b0, input lookup_res_t want = '0);
        lookup_res_t predicted;
        int          gap;
        // The sender works in bursts, with a random gap before each one.
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        start       <= 1'b1;
        command     <= op;
        row_key     <= rk;
        col_key     <= ck;
        entry_value <= ev;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = store_step(op, rk, ck, ev);
        pending_results.push_back(fixed ? want : predicted);
        issued_items++;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic lookup_beat();
        op_t              op;
        int               r;
        int               s;
        logic [KEY_W-1:0] rk;
        logic [KEY_W-1:0] ck;
        op = $urandom_range(0, 1) ? OP_GLOBAL : OP_LOCAL;
        if (sh_rows > 0 && $urandom_range(0, 4) != 0)
        begin
            // A stored row, mostly with one of its stored columns.
            r  = $urandom_range(0, sh_rows - 1);
            rk = (op == OP_LOCAL) ? KEY_W'(r + 1) : sh_row_id[r];
            if ($urandom_range(0, 3) != 0)
            begin
                s  = $urandom_range(sh_row_start[r], sh_row_start[r + 1] - 1);
                ck = sh_col[s];
            end
            else
            begin
                ck = pick_col();
            end
        end
        else
        begin
            rk = (op == OP_LOCAL) ? KEY_W'($urandom_range(0, sh_rows + 2)) : pick_row_id();
            ck = pick_col();
        end
        issue(op, rk, ck, {$urandom, $urandom});
    endtask

    // Result checker: every done beat is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        lookup_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result beat: value %h offset %0d error %b",
                             value_out, offset_out, error_flag);
            end
            else
            begin
                want = pending_results.pop_front();
                if (value_out !== want.value || offset_out !== want.offset ||
                    error_flag !== want.err)
                begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("mismatch: expected %h %0d %b, got %h %0d %b",
                                 want.value, want.offset, want.err,
                                 value_out, offset_out, error_flag);
                end
            end
        end
    end

    // Watchdog over cycles in which no beat moves in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int               i;
        int               j;
        int               n_rows;
        int               n_ent;
        int               n_look;
        int               target;
        logic [KEY_W-1:0] id;
        sh_rows         = 0;
        sh_entries      = 0;
        sh_row_start[0] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (dir_tab[k])
            issue(dir_tab[k].op, dir_tab[k].rk, dir_tab[k].ck, dir_tab[k].ev,
                  dir_tab[k].fixed, dir_tab[k].want);
        wait_drained();

        // Random part: mostly row builds and lookups into them, some noise.
        target = issued_items + RANDOM_ITEMS;
        while (issued_items < target)
        begin
            if ($urandom_range(0, 24) == 0)
                wait_drained();
            case ($urandom_range(0, 9))
                0:
                begin
                    issue(op_t'($urandom_range(0, 3)), $urandom, $urandom, {$urandom, $urandom});
                end
                1, 2, 3, 4:
                begin
                    if (sh_entries > 120 || $urandom_range(0, 3) == 0)
                        issue(OP_CLEAR, $urandom, $urandom, {$urandom, $urandom});
                    n_rows = $urandom_range(1, 6);
                    for (i = 0; i < n_rows; i++)
                    begin
                        id    = pick_row_id();
                        n_ent = $urandom_range(1, 5);
                        for (j = 0; j < n_ent; j++)
                            issue(OP_APPEND, id, pick_col(), {$urandom, $urandom});
                    end
                end
                default:
                begin
                    n_look = $urandom_range(1, 6);
                    for (i = 0; i < n_look; i++)
                        lookup_beat();
                end
            endcase
        end

        // Capacity: fill every row, probe the full row table, then look up into it.
        wait_drained();
        issue(OP_CLEAR, '0, '0, '0);
        for (i = 1; i <= MAX_ROWS; i++)
            issue(OP_APPEND, KEY_W'(i), KEY_W'(i), {$urandom, $urandom});
        issue(OP_APPEND, 32'd1000, 32'd1, {$urandom, $urandom}, 1'b1,
              '{64'd0, OFF_W'(MAX_ROWS), 1'b1});
        issue(OP_APPEND, KEY_W'(MAX_ROWS), 32'd5, {$urandom, $urandom});
        issue(OP_GLOBAL, KEY_W'(MAX_ROWS), 32'd5, {$urandom, $urandom});
        issue(OP_GLOBAL, KEY_W'(MAX_ROWS), 32'd7, {$urandom, $urandom});
        issue(OP_LOCAL, KEY_W'(MAX_ROWS), KEY_W'(MAX_ROWS), {$urandom, $urandom});
        issue(OP_GLOBAL, 32'd1, 32'd1, {$urandom, $urandom});
        issue(OP_LOCAL, KEY_W'(MAX_ROWS + 1), 32'd1, {$urandom, $urandom}, 1'b1,
              '{64'd0, 11'd0, 1'b1});
        issue(OP_CLEAR, '0, '0, '0);

        // Drain, then watch a little longer for stray result beats.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
